// ===== hdl/bkq_pkg.sv =====
`timescale 1ns / 1ps

package bkq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam int TAG_W      = 16;
    localparam int RAND_W     = 16;
    localparam int PROB_W     = 17;
    localparam int CHAN_W     = 8;
    localparam int EXP_W      = 5;
    localparam int BACKOFF_W  = 17;
    localparam int QUEUED_W   = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;

    // Channel actions.
    localparam logic [1:0] ACT_ARRIVAL = 2'd0;
    localparam logic [1:0] ACT_TRIGGER = 2'd1;
    localparam logic [1:0] ACT_ACK     = 2'd2;
    localparam logic [1:0] ACT_NACK    = 2'd3;

    // Result outcomes.
    localparam logic [2:0] OUT_STORED   = 3'd0;
    localparam logic [2:0] OUT_DROPPED  = 3'd1;
    localparam logic [2:0] OUT_COUNTING = 3'd2;
    localparam logic [2:0] OUT_BACKOFF  = 3'd3;
    localparam logic [2:0] OUT_SENT     = 3'd4;
    localparam logic [2:0] OUT_IDLE     = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SEND_PROB = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_CHAN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXP_CAP   = 2'd2;

    localparam logic [PROB_W-1:0] SEND_PROB_RESET = 17'd32768;
    localparam logic [CHAN_W-1:0] NUM_CHAN_RESET  = 8'd1;
    localparam logic [EXP_W-1:0]  EXP_CAP_RESET   = 5'd10;
    localparam logic [EXP_W-1:0]  EXP_RESET       = 5'd1;
    localparam logic [EXP_W-1:0]  EXP_MAX         = 5'd16;

    typedef struct packed {
        logic [1:0]        action;
        logic [TAG_W-1:0]  packet_tag;
        logic [RAND_W-1:0] rand_backoff;
        logic [RAND_W-1:0] rand_send;
        logic [RAND_W-1:0] rand_channel;
    } bkq_in_t;

    typedef struct packed {
        logic [2:0]           outcome;
        logic                 send_valid;
        logic [TAG_W-1:0]     sent_tag;
        logic [CHAN_W-1:0]    sent_channel;
        logic [BACKOFF_W-1:0] backoff_left;
        logic [QUEUED_W-1:0]  queued;
    } bkq_out_t;

endpackage

// ===== hdl/bkq_mem.sv =====
`timescale 1ns / 1ps

module bkq_mem #(
    parameter int DEPTH = bkq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int WIDTH = bkq_pkg::TAG_W
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/backoff_transmit_queue.sv =====
`timescale 1ns / 1ps

// Channel  Ports                          Payload      Direction
// input    s_valid s_ready s_data         bkq_in_t     in
// result   m_valid m_ready m_data         bkq_out_t    out
// config   cfg_we cfg_addr cfg_wdata      17-bit data  in
//
// For each word, the accept cycle issues the read of the packet store at
// the head that the word will look at, and the execute state that follows
// uses the registered read data and updates the queue and backoff state.
// A new word is accepted only after the last word has been executed.
// A stalled result holds the block in its execute state until m_ready.
// Reset is synchronous and active low; the packet store needs no clearing.

module backoff_transmit_queue #(
    parameter int QUEUE_DEPTH = bkq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bkq_pkg::bkq_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bkq_pkg::bkq_out_t                   m_data,
    input  logic                                cfg_we,
    input  logic [bkq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [bkq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    import bkq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [BACKOFF_W-1:0] backoff_reg, backoff_next;
    logic [EXP_W-1:0]     exp_reg, exp_next;
    logic [PROB_W-1:0]    prob_reg, prob_next;
    logic [CHAN_W-1:0]    nch_reg, nch_next;
    logic [EXP_W-1:0]     cap_reg, cap_next;
    bkq_in_t              item_reg;
    logic                 out_valid_reg, out_valid_next;
    bkq_out_t             out_data_reg, out_data_next;

    logic                 accept;
    logic                 fire;
    logic                 full;
    logic [PTR_W-1:0]     rd_addr;
    logic [TAG_W-1:0]     rd_data;
    logic                 wr_en;
    logic [EXP_W-1:0]     cap_eff;
    logic [EXP_W-1:0]     exp_inc;
    logic [BACKOFF_W-1:0] win_mask;
    logic [CHAN_W:0]      chan_span;
    logic [RAND_W+CHAN_W:0] chan_prod;
    logic [CNT_W-1:0]     fill_after;
    logic [CNT_W+QUEUED_W-1:0] fill_ext;

    function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign fire    = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
    assign full    = (fill_reg == CNT_W'(QUEUE_DEPTH));

    // An ACK that pops makes the word after the head the one to send.
    assign rd_addr = (s_data.action == ACT_ACK && fill_reg != '0) ?
                     next_index(head_reg) : head_reg;

    assign wr_en = fire && (item_reg.action == ACT_ARRIVAL) && !full;

    bkq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TAG_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (item_reg.packet_tag),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = EXP_W'(1);
        end else if (cap_reg > EXP_MAX) begin
            cap_eff = EXP_MAX;
        end else begin
            cap_eff = cap_reg;
        end
        exp_inc   = (exp_reg + 1'b1 > cap_eff) ? cap_eff : exp_reg + 1'b1;
        win_mask  = (BACKOFF_W'(1) << exp_inc) - 1'b1;
        chan_span = {1'b0, nch_reg} + 1'b1;
        chan_prod = item_reg.rand_channel * chan_span;
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        backoff_next   = backoff_reg;
        exp_next       = exp_reg;
        prob_next      = prob_reg;
        nch_next       = nch_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        fill_after     = fill_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SEND_PROB: prob_next = cfg_wdata[PROB_W-1:0];
                CFG_NUM_CHAN:  nch_next  = cfg_wdata[CHAN_W-1:0];
                CFG_EXP_CAP:   cap_next  = cfg_wdata[EXP_W-1:0];
                default: ;
            endcase
        end

        if (accept) begin
            state_next = ST_EXEC;
        end

        if (fire) begin
            state_next             = ST_IDLE;
            out_valid_next         = 1'b1;
            out_data_next.send_valid   = 1'b0;
            out_data_next.sent_tag     = '0;
            out_data_next.sent_channel = '0;

            if (item_reg.action == ACT_ARRIVAL) begin
                if (full) begin
                    out_data_next.outcome = OUT_DROPPED;
                end else begin
                    tail_next             = next_index(tail_reg);
                    fill_next             = fill_reg + 1'b1;
                    out_data_next.outcome = OUT_STORED;
                end
            end else if (backoff_reg != '0) begin
                backoff_next          = backoff_reg - 1'b1;
                out_data_next.outcome = OUT_COUNTING;
            end else if (item_reg.action == ACT_NACK) begin
                exp_next              = exp_inc;
                backoff_next          = BACKOFF_W'(item_reg.rand_backoff &
                                                   win_mask[RAND_W-1:0]) + 1'b1;
                out_data_next.outcome = OUT_BACKOFF;
            end else begin
                if (item_reg.action == ACT_ACK) begin
                    if (fill_reg != '0) begin
                        head_next  = next_index(head_reg);
                        fill_after = fill_reg - 1'b1;
                    end
                    exp_next = EXP_RESET;
                end
                fill_next = fill_after;
                if (fill_after != '0 && PROB_W'(item_reg.rand_send) < prob_reg) begin
                    out_data_next.outcome      = OUT_SENT;
                    out_data_next.send_valid   = 1'b1;
                    out_data_next.sent_tag     = rd_data;
                    out_data_next.sent_channel = chan_prod[RAND_W +: CHAN_W];
                end else begin
                    out_data_next.outcome = OUT_IDLE;
                end
            end

            fill_ext                   = {{QUEUED_W{1'b0}}, fill_next};
            out_data_next.backoff_left = backoff_next;
            out_data_next.queued       = fill_ext[QUEUED_W-1:0];
        end else begin
            fill_ext = {{QUEUED_W{1'b0}}, fill_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            backoff_reg   <= '0;
            exp_reg       <= EXP_RESET;
            prob_reg      <= SEND_PROB_RESET;
            nch_reg       <= NUM_CHAN_RESET;
            cap_reg       <= EXP_CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            backoff_reg   <= backoff_next;
            exp_reg       <= exp_next;
            prob_reg      <= prob_next;
            nch_reg       <= nch_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        if (accept) begin
            item_reg <= s_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second word accepted while one is in work");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> fill_reg == $past(fill_reg))
        else $error("queue count changed without a word in work");

    a_send_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.send_valid |-> m_data.outcome == OUT_SENT
                                         && m_data.queued != '0)
        else $error("send flagged without sent outcome or with empty queue");
`endif

endmodule
